FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define VNR_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define VNR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/vnr_pkg.sv
// ----------------------------------------------------------------------------
// vnr_pkg
// Types, constants and codes shared by the von Neumann ratio block.
// ----------------------------------------------------------------------------
`default_nettype none

package vnr_pkg;

    localparam int DATA_W          = 32;
    localparam int KCOUNT_W        = 17;
    localparam int STATUS_W        = 2;
    localparam int ADDR_W          = 3;
    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QDEPTH          = 2;     // power of two
    localparam int MUL_W           = 64;
    localparam int PROD_W          = 128;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_VAR = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SAT      = 2'd3;

    localparam logic REG_WEIGHTED = 1'b0;
    localparam logic REG_MASK     = 1'b1;

    typedef struct packed {
        logic weighted_mode;
        logic use_mask;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] magnitude;
        logic [DATA_W-1:0] uncertainty;
        logic              keep;
        logic              last;
        logic              wmode;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] n;
        logic [PROD_W-1:0] d;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] q;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_WDIV, S_WSET, S_VAL, S_VACC, S_SQ, S_SQACC,
        S_AD2, S_PU2, S_WPSET, S_PAIR, S_PACC, S_ADV, S_LAST, S_FSQ,
        S_FV, S_VCHK, S_FNUM, S_FDEN, S_FQ, S_OUT, S_MWAIT, S_DWAIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/vnr_front.sv
// ----------------------------------------------------------------------------
// vnr_front
// Accepts samples, applies the validity and mask filters, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module vnr_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vnr_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [vnr_pkg::DATA_W-1:0] magnitude,
    input  logic [vnr_pkg::DATA_W-1:0] uncertainty,
    input  logic                       magnitude_valid,
    input  logic                       uncertainty_valid,
    input  logic                       keep_point,
    input  logic                       last_sample,
    output logic                       q_valid,
    output vnr_pkg::item_t             q_item,
    input  logic                       q_pop
);

    localparam int PTR_W = (vnr_pkg::QDEPTH > 1) ? $clog2(vnr_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(vnr_pkg::QDEPTH + 1);

    vnr_pkg::item_t   mem_reg [vnr_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;
    logic             keep;
    vnr_pkg::item_t   entry;

    assign in_stall = (cnt_reg == CNT_W'(vnr_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        keep = magnitude_valid;
        if (cfg.weighted_mode && (!uncertainty_valid || uncertainty == '0))
        begin
            keep = 1'b0;
        end
        if (cfg.use_mask && !keep_point)
        begin
            keep = 1'b0;
        end
        entry.magnitude   = magnitude;
        entry.uncertainty = uncertainty;
        entry.keep        = keep;
        entry.last        = last_sample;
        entry.wmode       = cfg.weighted_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vnr_mul.sv
// ----------------------------------------------------------------------------
// vnr_mul
// 64x64 multiplier built from four 32x32 partial products over cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module vnr_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  vnr_pkg::mul_req_t req,
    output vnr_pkg::mul_rsp_t rsp
);

    localparam int H_W   = vnr_pkg::MUL_W / 2;
    localparam int STEPS = 4;

    logic [vnr_pkg::MUL_W-1:0]  a_reg;
    logic [vnr_pkg::MUL_W-1:0]  b_reg;
    logic [vnr_pkg::MUL_W-1:0]  prod_reg;
    logic [1:0]                 psh_reg;
    logic                       pv_reg;
    logic [2:0]                 step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [vnr_pkg::PROD_W-1:0] acc_reg;
    logic [H_W-1:0]             ah;
    logic [H_W-1:0]             bh;
    logic [1:0]                 sh;
    logic [vnr_pkg::PROD_W-1:0] part;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    begin ah = a_reg[H_W-1:0];   bh = b_reg[H_W-1:0];   sh = 2'd0; end
            2'd1:    begin ah = a_reg[H_W-1:0];   bh = b_reg[2*H_W-1:H_W]; sh = 2'd1; end
            2'd2:    begin ah = a_reg[2*H_W-1:H_W]; bh = b_reg[H_W-1:0];   sh = 2'd1; end
            default: begin ah = a_reg[2*H_W-1:H_W]; bh = b_reg[2*H_W-1:H_W]; sh = 2'd2; end
        endcase
        part = {{(vnr_pkg::PROD_W - vnr_pkg::MUL_W){1'b0}}, prod_reg} << (H_W * psh_reg);
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pv_reg   <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                pv_reg   <= 1'b0;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg < 3'(STEPS))
                begin
                    pv_reg   <= 1'b1;
                    step_reg <= step_reg + 1'b1;
                end
                else
                begin
                    pv_reg   <= 1'b0;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else
        begin
            prod_reg <= vnr_pkg::MUL_W'(ah) * vnr_pkg::MUL_W'(bh);
            psh_reg  <= sh;
            if (pv_reg)
            begin
                acc_reg <= acc_reg + part;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vnr_div.sv
// ----------------------------------------------------------------------------
// vnr_div
// 128-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vnr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  vnr_pkg::div_req_t req,
    output vnr_pkg::div_rsp_t rsp
);

    localparam int W     = vnr_pkg::PROD_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     nq_reg;
    logic [W-1:0]     d_reg;
    logic [W-1:0]     r_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       rs;
    logic [W:0]       diff;
    logic             ge;

    assign rs   = {r_reg, nq_reg[W-1]};
    assign diff = rs - {1'b0, d_reg};
    assign ge   = !diff[W];

    assign rsp.done = done_reg;
    assign rsp.q    = nq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= CNT_W'(W - 1);
                if (req.d == '0)
                begin
                    done_reg <= 1'b1;   // zero divisor: all ones
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            nq_reg <= (req.d == '0) ? '1 : req.n;
            d_reg  <= req.d;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            r_reg  <= ge ? diff[W-1:0] : rs[W-1:0];
            nq_reg <= {nq_reg[W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vnr_back.sv
// ----------------------------------------------------------------------------
// vnr_back
// Sequencer: per-sample weights and sums, then the ratio at series end.
// ----------------------------------------------------------------------------
`default_nettype none

module vnr_back #(
    parameter int MAX_SAMPLES = vnr_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = vnr_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  vnr_pkg::item_t               q_item,
    output logic                         q_pop,
    output vnr_pkg::mul_req_t            mul_req,
    input  vnr_pkg::mul_rsp_t            mul_rsp,
    output vnr_pkg::div_req_t            div_req,
    input  vnr_pkg::div_rsp_t            div_rsp,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [vnr_pkg::DATA_W-1:0]   ratio,
    output logic [vnr_pkg::KCOUNT_W-1:0] kept_count,
    output logic [vnr_pkg::STATUS_W-1:0] status
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int PW    = vnr_pkg::PROD_W;
    localparam int MW    = vnr_pkg::MUL_W;
    localparam logic [MW-1:0] ONE  = MW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] NUM3 = PW'(1) << (3 * FRAC_BITS);
    localparam logic [MW-1:0] SLIM = {1'b0, {(MW-1){1'b1}}};

    vnr_pkg::back_state_t state_reg, state_next;
    vnr_pkg::back_state_t ret_reg, ret_next;

    vnr_pkg::item_t  it_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MW-1:0]   wsum_reg;
    logic [MW-1:0]   wvs_reg;     // signed
    logic [MW-1:0]   wss_reg;
    logic [MW-1:0]   pds_reg;
    logic [31:0]     pmag_reg;
    logic [31:0]     punc_reg;
    logic            sat_reg;
    logic [MW-1:0]   w_reg;
    logic [MW-1:0]   wp_reg;
    logic [MW-1:0]   u2_reg;
    logic [MW-1:0]   ad2_reg;
    logic [MW-1:0]   v_reg;
    logic [PW-1:0]   num_reg;
    logic [31:0]     rratio_reg;
    logic [1:0]      rstat_reg;
    logic            ovalid_reg;
    logic [31:0]     ratio_reg;
    logic [vnr_pkg::KCOUNT_W-1:0] kcount_reg;
    logic [1:0]      status_reg;

    logic [PW-1:0] p;
    logic [PW-1:0] q;
    logic [PW-1:0] p_f;
    logic [PW-1:0] p_2f;
    logic          q_ovf;
    logic [MW-1:0] wq;
    logic          m_ovf;
    logic [MW-1:0] m64;
    logic [MW-1:0] m_cl;
    logic          m_big;
    logic [MW+1:0] t;
    logic [MW+1:0] vsum;
    logic [MW+1:0] slim_p;
    logic [MW+1:0] slim_n;
    logic          t_ovf;
    logic [MW-1:0] term2;
    logic [MW:0]   wsum_add;
    logic [MW:0]   wss_add;
    logic [MW:0]   pds_add;
    logic [31:0]   ay;
    logic [32:0]   dy;
    logic [32:0]   ndy;
    logic [31:0]   ad;
    logic [MW-1:0] as;
    logic [MW-1:0] v_calc;
    logic [MW-1:0] n64;
    logic [MW-1:0] kn;
    logic          clip;
    logic          out_free;
    logic          cnt_full;

    assign p = mul_rsp.p;
    assign q = div_rsp.q;

    always_comb
    begin
        p_f   = p >> FRAC_BITS;
        p_2f  = p >> (2 * FRAC_BITS);
        q_ovf = (q[PW-1:MW] != '0);
        wq    = q_ovf ? '1 : q[MW-1:0];
        m_ovf = (p_f[PW-1:MW] != '0);
        m64   = m_ovf ? '1 : p_f[MW-1:0];
        m_big = (m64 > SLIM);
        m_cl  = m_big ? SLIM : m64;
        t     = it_reg.magnitude[31] ? (MW+2)'(-{2'b00, m_cl}) : {2'b00, m_cl};
        vsum  = {{2{wvs_reg[MW-1]}}, wvs_reg} + t;
        slim_p = {2'b00, SLIM};
        slim_n = (MW+2)'(-{2'b00, SLIM});
        t_ovf = 1'b0;
        if ($signed(vsum) > $signed(slim_p))
        begin
            vsum  = slim_p;
            t_ovf = 1'b1;
        end
        else if ($signed(vsum) < $signed(slim_n))
        begin
            vsum  = slim_n;
            t_ovf = 1'b1;
        end
        term2    = (p_2f[PW-1:MW] != '0) ? '1 : p_2f[MW-1:0];
        wsum_add = {1'b0, wsum_reg} + {1'b0, w_reg};
        wss_add  = {1'b0, wss_reg} + {1'b0, term2};
        pds_add  = {1'b0, pds_reg} + {1'b0, term2};
        ay       = it_reg.magnitude[31] ? (~it_reg.magnitude + 32'd1) : it_reg.magnitude;
        dy       = {it_reg.magnitude[31], it_reg.magnitude} - {pmag_reg[31], pmag_reg};
        ndy      = -dy;
        ad       = dy[32] ? ndy[31:0] : dy[31:0];
        as       = wvs_reg[MW-1] ? (~wvs_reg + MW'(1)) : wvs_reg;
        v_calc   = (!q_ovf && wss_reg >= q[MW-1:0]) ? (wss_reg - q[MW-1:0]) : '0;
        n64      = MW'(cnt_reg);
        kn       = it_reg.wmode ? {n64[MW-2:0], 1'b0} : n64;
        clip     = (q[PW-1:32] != '0);
        out_free = !ovalid_reg || !out_stall;
        cnt_full = (cnt_reg >= CNT_W'(MAX_SAMPLES));
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vnr_pkg::S_IDLE;
            ret_reg   <= vnr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // next state, queue pop and arithmetic requests
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        q_pop         = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        div_req.start = 1'b0;
        div_req.n     = '0;
        div_req.d     = '0;
        unique case (state_reg)
            vnr_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = vnr_pkg::S_CHECK;
                end
            end
            vnr_pkg::S_CHECK:
            begin
                if (!it_reg.keep || cnt_full)
                begin
                    state_next = vnr_pkg::S_LAST;
                end
                else if (it_reg.wmode)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MW'(it_reg.uncertainty);
                    mul_req.b     = MW'(it_reg.uncertainty);
                    ret_next      = vnr_pkg::S_WDIV;
                    state_next    = vnr_pkg::S_MWAIT;
                end
                else
                begin
                    state_next = vnr_pkg::S_VAL;
                end
            end
            vnr_pkg::S_WDIV:
            begin
                div_req.start = 1'b1;
                div_req.n     = NUM3;
                div_req.d     = p;
                ret_next      = vnr_pkg::S_WSET;
                state_next    = vnr_pkg::S_DWAIT;
            end
            vnr_pkg::S_WSET:  state_next = vnr_pkg::S_VAL;
            vnr_pkg::S_VAL:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MW'(ay);
                mul_req.b     = w_reg;
                ret_next      = vnr_pkg::S_VACC;
                state_next    = vnr_pkg::S_MWAIT;
            end
            vnr_pkg::S_VACC:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MW'(ay);
                mul_req.b     = MW'(ay);
                ret_next      = vnr_pkg::S_SQ;
                state_next    = vnr_pkg::S_MWAIT;
            end
            vnr_pkg::S_SQ:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = p[MW-1:0];
                mul_req.b     = w_reg;
                ret_next      = vnr_pkg::S_SQACC;
                state_next    = vnr_pkg::S_MWAIT;
            end
            vnr_pkg::S_SQACC:
            begin
                if (cnt_reg != '0)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MW'(ad);
                    mul_req.b     = MW'(ad);
                    ret_next      = vnr_pkg::S_AD2;
                    state_next    = vnr_pkg::S_MWAIT;
                end
                else
                begin
                    state_next = vnr_pkg::S_ADV;
                end
            end
            vnr_pkg::S_AD2:
            begin
                if (it_reg.wmode)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MW'(punc_reg);
                    mul_req.b     = MW'(punc_reg);
                    ret_next      = vnr_pkg::S_PU2;
                    state_next    = vnr_pkg::S_MWAIT;
                end
                else
                begin
                    state_next = vnr_pkg::S_PAIR;
                end
            end
            vnr_pkg::S_PU2:
            begin
                div_req.start = 1'b1;
                div_req.n     = NUM3;
                div_req.d     = PW'({1'b0, p[MW-1:0]} + {1'b0, u2_reg});
                ret_next      = vnr_pkg::S_WPSET;
                state_next    = vnr_pkg::S_DWAIT;
            end
            vnr_pkg::S_WPSET: state_next = vnr_pkg::S_PAIR;
            vnr_pkg::S_PAIR:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = ad2_reg;
                mul_req.b     = wp_reg;
                ret_next      = vnr_pkg::S_PACC;
                state_next    = vnr_pkg::S_MWAIT;
            end
            vnr_pkg::S_PACC:  state_next = vnr_pkg::S_ADV;
            vnr_pkg::S_ADV:   state_next = vnr_pkg::S_LAST;
            vnr_pkg::S_LAST:
            begin
                if (!it_reg.last)
                begin
                    state_next = vnr_pkg::S_IDLE;
                end
                else if (cnt_reg < CNT_W'(2))
                begin
                    state_next = vnr_pkg::S_OUT;
                end
                else if (wsum_reg == '0)
                begin
                    state_next = vnr_pkg::S_VCHK;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = as;
                    mul_req.b     = as;
                    ret_next      = vnr_pkg::S_FSQ;
                    state_next    = vnr_pkg::S_MWAIT;
                end
            end
            vnr_pkg::S_FSQ:
            begin
                div_req.start = 1'b1;
                div_req.n     = p;
                div_req.d     = PW'(wsum_reg);
                ret_next      = vnr_pkg::S_FV;
                state_next    = vnr_pkg::S_DWAIT;
            end
            vnr_pkg::S_FV:    state_next = vnr_pkg::S_VCHK;
            vnr_pkg::S_VCHK:
            begin
                if (v_reg == '0)
                begin
                    state_next = vnr_pkg::S_OUT;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = pds_reg;
                    mul_req.b     = kn;
                    ret_next      = vnr_pkg::S_FNUM;
                    state_next    = vnr_pkg::S_MWAIT;
                end
            end
            vnr_pkg::S_FNUM:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = v_reg;
                mul_req.b     = n64 - MW'(1);
                ret_next      = vnr_pkg::S_FDEN;
                state_next    = vnr_pkg::S_MWAIT;
            end
            vnr_pkg::S_FDEN:
            begin
                div_req.start = 1'b1;
                div_req.n     = num_reg;
                div_req.d     = p;
                ret_next      = vnr_pkg::S_FQ;
                state_next    = vnr_pkg::S_DWAIT;
            end
            vnr_pkg::S_FQ:    state_next = vnr_pkg::S_OUT;
            vnr_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = vnr_pkg::S_IDLE;
                end
            end
            vnr_pkg::S_MWAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ret_reg;
                end
            end
            vnr_pkg::S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ret_reg;
                end
            end
            default:          state_next = vnr_pkg::S_IDLE;
        endcase
    end

    // series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wsum_reg   <= '0;
            wvs_reg    <= '0;
            wss_reg    <= '0;
            pds_reg    <= '0;
            pmag_reg   <= '0;
            punc_reg   <= '0;
            sat_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                vnr_pkg::S_CHECK:
                begin
                    if (it_reg.keep && cnt_full)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                vnr_pkg::S_WSET:
                begin
                    if (q_ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                vnr_pkg::S_VAL:
                begin
                    wsum_reg <= wsum_add[MW] ? '1 : wsum_add[MW-1:0];
                    if (wsum_add[MW])
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                vnr_pkg::S_VACC:
                begin
                    wvs_reg <= vsum[MW-1:0];
                    if (m_ovf || m_big || t_ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                vnr_pkg::S_SQACC:
                begin
                    wss_reg <= wss_add[MW] ? '1 : wss_add[MW-1:0];
                    if (wss_add[MW] || p_2f[PW-1:MW] != '0)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                vnr_pkg::S_WPSET:
                begin
                    if (q_ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                vnr_pkg::S_PACC:
                begin
                    pds_reg <= pds_add[MW] ? '1 : pds_add[MW-1:0];
                    if (pds_add[MW] || p_2f[PW-1:MW] != '0)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                vnr_pkg::S_ADV:
                begin
                    pmag_reg <= it_reg.magnitude;
                    punc_reg <= it_reg.uncertainty;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                vnr_pkg::S_OUT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        cnt_reg    <= '0;
                        wsum_reg   <= '0;
                        wvs_reg    <= '0;
                        wss_reg    <= '0;
                        pds_reg    <= '0;
                        pmag_reg   <= '0;
                        punc_reg   <= '0;
                        sat_reg    <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result staging
    always_ff @(posedge clk)
    begin
        case (state_reg)
            vnr_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    it_reg <= q_item;
                end
            end
            vnr_pkg::S_CHECK: w_reg  <= ONE;
            vnr_pkg::S_WDIV:  u2_reg <= p[MW-1:0];
            vnr_pkg::S_WSET:  w_reg  <= wq;
            vnr_pkg::S_AD2:
            begin
                ad2_reg <= p[MW-1:0];
                wp_reg  <= ONE;
            end
            vnr_pkg::S_WPSET: wp_reg <= wq;
            vnr_pkg::S_LAST:
            begin
                v_reg      <= '0;
                rratio_reg <= '0;
                rstat_reg  <= vnr_pkg::STAT_FEW;
            end
            vnr_pkg::S_FV:    v_reg <= v_calc;
            vnr_pkg::S_VCHK:
            begin
                rratio_reg <= '0;
                rstat_reg  <= sat_reg ? vnr_pkg::STAT_SAT : vnr_pkg::STAT_ZERO_VAR;
            end
            vnr_pkg::S_FNUM:  num_reg <= p << FRAC_BITS;
            vnr_pkg::S_FQ:
            begin
                rratio_reg <= clip ? '1 : q[31:0];
                rstat_reg  <= (sat_reg || clip) ? vnr_pkg::STAT_SAT : vnr_pkg::STAT_OK;
            end
            vnr_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    ratio_reg  <= rratio_reg;
                    kcount_reg <= vnr_pkg::KCOUNT_W'(cnt_reg);
                    status_reg <= rstat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = ovalid_reg;
    assign ratio      = ratio_reg;
    assign kept_count = kcount_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

FILE: rtl/von_neumann_ratio_top.sv
// ----------------------------------------------------------------------------
// von_neumann_ratio_top
// Weighted or unweighted von Neumann ratio of a sample series, one sample per transfer.
// ----------------------------------------------------------------------------
// Samples arrive one per input transfer. The front end applies the validity
// and mask filters using the mode registers as they stand at that transfer and
// queues the sample (two entries). The back end works through one sample at a
// time with a shared 64x64 multiplier and a 128-bit restoring divider. The
// multiplier sums four 32x32 partial products; the divider takes one quotient
// bit per cycle. A dropped sample uses neither unit, and a kept weighted
// sample needs two reciprocal divisions (one for the first of a series). The
// sample marked last closes the series and adds the final ratio (up to three
// products and two divisions). One result transfer then carries ratio,
// kept_count and status. The result is held in an output register while the
// next series already starts. Status: 0 ok, 1 fewer than two kept samples,
// 2 zero variance, 3 saturation in a sum, weight, sample count or the ratio.
// Registers: offset 0 weighted_mode, offset 4 use_mask; change them only
// while the block is idle.
`default_nettype none

module von_neumann_ratio_top #(
    parameter int MAX_SAMPLES = vnr_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = vnr_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vnr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // sample input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [vnr_pkg::DATA_W-1:0] magnitude,
    input  logic [vnr_pkg::DATA_W-1:0]   uncertainty,
    input  logic                         magnitude_valid,
    input  logic                         uncertainty_valid,
    input  logic                         keep_point,
    input  logic                         last_sample,
    // result output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [vnr_pkg::DATA_W-1:0]   ratio,
    output logic [vnr_pkg::KCOUNT_W-1:0] kept_count,
    output logic [vnr_pkg::STATUS_W-1:0] status
);

`include "assert_macros.svh"

    vnr_pkg::cfg_t     cfg_reg;
    vnr_pkg::item_t    q_item;
    vnr_pkg::mul_req_t mul_req;
    vnr_pkg::mul_rsp_t mul_rsp;
    vnr_pkg::div_req_t div_req;
    vnr_pkg::div_rsp_t div_rsp;
    logic              q_valid;
    logic              q_pop;
    logic              cfg_wr;

    // APB: zero wait state, register index taken from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                vnr_pkg::REG_WEIGHTED: cfg_reg.weighted_mode <= pwdata[0];
                vnr_pkg::REG_MASK:     cfg_reg.use_mask      <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            vnr_pkg::REG_WEIGHTED: prdata = {31'b0, cfg_reg.weighted_mode};
            vnr_pkg::REG_MASK:     prdata = {31'b0, cfg_reg.use_mask};
            default:               prdata = '0;
        endcase
    end

    // front end: filter and queue
    vnr_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .magnitude         ($unsigned(magnitude)),
        .uncertainty       (uncertainty),
        .magnitude_valid   (magnitude_valid),
        .uncertainty_valid (uncertainty_valid),
        .keep_point        (keep_point),
        .last_sample       (last_sample),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop)
    );

    // back end: sums and ratio
    vnr_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ratio      (ratio),
        .kept_count (kept_count),
        .status     (status)
    );

    // shared arithmetic units
    vnr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    vnr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // the back end only pops a non-empty queue
    `VNR_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid)
    // a product is never ready the cycle after it is started
    `VNR_ASSERT_NEXT(a_mul_latency, mul_req.start, !mul_rsp.done)
    // one sequencer: the two units never finish together
    `VNR_ASSERT_IMPL(a_one_finish, mul_rsp.done, !div_rsp.done)
    // nor are they started together
    `VNR_ASSERT_IMPL(a_one_start, div_req.start, !mul_req.start)

endmodule

`default_nettype wire

FILE: tb/von_neumann_ratio_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// von_neumann_ratio_top_tb
// Self-checking bench for the von Neumann ratio block: sample series are fed
// through the input channel, a local model of the running sums predicts each
// series result, and the monitor checks ratio, kept_count and status per
// transfer. Both channels idle and stall at random; modes are changed over
// APB between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module von_neumann_ratio_top_tb;

    localparam int            FRAC       = vnr_pkg::FRAC_BITS_DEF;
    localparam logic [63:0]   SLIM       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [127:0]  RECIP_NUM  = 128'd1 << (3 * FRAC);
    localparam logic [63:0]   UNIT       = 64'd1 << FRAC;
    localparam int            CYCLE_CAP  = 4_000_000;
    localparam int            DRAIN_WAIT = 800;   // worst weighted sample plus close-out

    typedef struct {
        logic [31:0] mag;
        logic [31:0] unc;
        logic        mag_ok;
        logic        unc_ok;
        logic        keep;
        logic        last;
    } sample_t;

    typedef struct {
        logic [31:0]                  ratio;
        logic [vnr_pkg::KCOUNT_W-1:0] count;
        logic [vnr_pkg::STATUS_W-1:0] status;
    } series_result_t;

    // DUT connections; the bench-driven inputs are known from time zero
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [vnr_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [31:0]           magnitude = '0;
    logic [31:0]                  uncertainty = '0;
    logic                         magnitude_valid = 1'b0, uncertainty_valid = 1'b0;
    logic                         keep_point = 1'b0, last_sample = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [31:0]                  ratio;
    logic [vnr_pkg::KCOUNT_W-1:0] kept_count;
    logic [vnr_pkg::STATUS_W-1:0] status;

    von_neumann_ratio_top u_top (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .in_valid, .in_stall, .magnitude, .uncertainty, .magnitude_valid,
        .uncertainty_valid, .keep_point, .last_sample,
        .out_valid, .out_stall, .ratio, .kept_count, .status
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Series model: local copies of mode registers and running sums
    // ------------------------------------------------------------------------
    logic               mode_weighted = 1'b0;
    logic               mode_mask = 1'b0;
    int unsigned        n_kept;
    logic [63:0]        sum_w, sum_sq, sum_diff;
    logic signed [63:0] sum_val;
    logic [31:0]        prev_mag, prev_unc;
    logic               clipped;

    series_result_t     result_q[$];
    sample_t            sample_q[$];
    int unsigned        pushed_n = 0, accepted_n = 0;
    int unsigned        mismatches = 0;
    bit                 quiet = 1'b0;     // no idling on either side

    function automatic logic [63:0] clip64(input logic [127:0] x);
        if (x[127:64] != 0)
        begin
            clipped = 1'b1;
            return '1;
        end
        return x[63:0];
    endfunction

    function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64])
        begin
            clipped = 1'b1;
            return '1;
        end
        return s[63:0];
    endfunction

    function automatic void clear_series();
        n_kept = 0;
        sum_w = '0;
        sum_val = '0;
        sum_sq = '0;
        sum_diff = '0;
        prev_mag = '0;
        prev_unc = '0;
        clipped = 1'b0;
    endfunction

    // Fold one kept sample into the running sums.
    function automatic void absorb_sample(input logic [31:0] mag, input logic [31:0] unc);
        logic signed [63:0] y, t, dy;
        logic [63:0]        ay, ad, w, wp, m;
        logic [127:0]       den;
        y  = {{32{mag[31]}}, mag};
        ay = (y < 0) ? -y : y;
        w  = mode_weighted ? clip64(RECIP_NUM / ({96'd0, unc} * {96'd0, unc})) : UNIT;
        sum_w = add_clip(sum_w, w);

        m = clip64(({64'd0, ay} * {64'd0, w}) >> FRAC);
        if (m > SLIM)
        begin
            m = SLIM;
            clipped = 1'b1;
        end
        t = (y < 0) ? -$signed(m) : $signed(m);
        if (t > 0 && sum_val > $signed(SLIM) - t)
        begin
            sum_val = SLIM;
            clipped = 1'b1;
        end
        else if (t < 0 && sum_val < -$signed(SLIM) - t)
        begin
            sum_val = -$signed(SLIM);
            clipped = 1'b1;
        end
        else
            sum_val = sum_val + t;

        sum_sq = add_clip(sum_sq, clip64(({64'd0, ay * ay} * {64'd0, w}) >> (2 * FRAC)));

        if (n_kept > 0)
        begin
            dy = y - $signed({{32{prev_mag[31]}}, prev_mag});
            ad = (dy < 0) ? -dy : dy;
            wp = UNIT;
            if (mode_weighted)
            begin
                den = {96'd0, prev_unc} * {96'd0, prev_unc} + {96'd0, unc} * {96'd0, unc};
                wp  = clip64(RECIP_NUM / den);
            end
            sum_diff = add_clip(sum_diff,
                clip64(({64'd0, ad * ad} * {64'd0, wp}) >> (2 * FRAC)));
        end
        prev_mag = mag;
        prev_unc = unc;
        n_kept++;
    endfunction

    // Ratio, count and status at series end; clears the series afterwards.
    function automatic series_result_t close_series();
        series_result_t r;
        logic [63:0]    v, as;
        logic [127:0]   q, num, den;
        r.ratio  = '0;
        r.count  = n_kept[vnr_pkg::KCOUNT_W-1:0];
        r.status = vnr_pkg::STAT_OK;
        if (n_kept < 2)
            r.status = vnr_pkg::STAT_FEW;
        else
        begin
            v = '0;
            if (sum_w != 0)
            begin
                as = (sum_val < 0) ? -sum_val : sum_val;
                q  = ({64'd0, as} * {64'd0, as}) / {64'd0, sum_w};
                if (q[127:64] == 0 && sum_sq >= q[63:0])
                    v = sum_sq - q[63:0];
            end
            if (v != 0)
            begin
                num = ({64'd0, sum_diff} * (mode_weighted ? 128'(2 * n_kept) : 128'(n_kept)))
                      << FRAC;
                den = {64'd0, v} * 128'(n_kept - 1);
                q   = num / den;
                if (q > 128'hFFFF_FFFF)
                begin
                    r.ratio = '1;
                    clipped = 1'b1;
                end
                else
                    r.ratio = q[31:0];
                r.status = clipped ? vnr_pkg::STAT_SAT : vnr_pkg::STAT_OK;
            end
            else
                r.status = clipped ? vnr_pkg::STAT_SAT : vnr_pkg::STAT_ZERO_VAR;
        end
        clear_series();
        return r;
    endfunction

    // Filters exactly as the block applies them at the moment of the transfer.
    function automatic void take_sample(input sample_t s);
        logic keep;
        keep = s.mag_ok;
        if (mode_weighted && (!s.unc_ok || s.unc == 0))
            keep = 1'b0;
        if (mode_mask && !s.keep)
            keep = 1'b0;
        if (keep)
        begin
            if (n_kept >= vnr_pkg::MAX_SAMPLES_DEF)
                clipped = 1'b1;
            else
                absorb_sample(s.mag, s.unc);
        end
        if (s.last)
            result_q.push_back(close_series());
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: one transfer per accepted item, payload held while stalled
    // ------------------------------------------------------------------------
    int unsigned in_gap;

    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_t nx;
        logic    took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                nx.mag    = magnitude;
                nx.unc    = uncertainty;
                nx.mag_ok = magnitude_valid;
                nx.unc_ok = uncertainty_valid;
                nx.keep   = keep_point;
                nx.last   = last_sample;
                take_sample(nx);
                accepted_n++;
            end
            if (!in_valid || took)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    nx = sample_q.pop_front();
                    magnitude         <= nx.mag;
                    uncertainty       <= nx.unc;
                    magnitude_valid   <= nx.mag_ok;
                    uncertainty_valid <= nx.unc_ok;
                    keep_point        <= nx.keep;
                    last_sample       <= nx.last;
                    in_valid          <= 1'b1;
                    in_gap            <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and random back-pressure
    // ------------------------------------------------------------------------
    int unsigned stall_left;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        series_result_t exp_r;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: ratio %h count %0d status %0d",
                                 ratio, kept_count, status);
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (ratio !== exp_r.ratio || kept_count !== exp_r.count
                        || status !== exp_r.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     exp_r.ratio, exp_r.count, exp_r.status,
                                     ratio, kept_count, status);
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= pick_gap();
            end
        end
    end

    // watchdog
    int unsigned cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("von_neumann_ratio_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push(input logic [31:0] mag, input logic [31:0] unc, input logic mok,
                        input logic uok, input logic kp, input logic lst);
        sample_t s;
        s.mag = mag; s.unc = unc; s.mag_ok = mok; s.unc_ok = uok; s.keep = kp; s.last = lst;
        sample_q.push_back(s);
        pushed_n++;
    endtask

    // register write, setup then access; only called while idle
    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vnr_pkg::ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == vnr_pkg::REG_WEIGHTED)
            mode_weighted = val[0];
        else
            mode_mask = val[0];
    endtask

    task automatic drain();
        while (accepted_n != pushed_n || result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_unc();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 32'd0;
        if (r < 8)  return 32'd1;
        if (r < 13) return $urandom;
        if (r < 15) return 32'hFFFF_FFFF;
        return $urandom_range(32'h100, 32'h40000);
    endfunction

    // One well-formed series with random content; style picks the value spread.
    task automatic random_series(input int unsigned len);
        int unsigned       style, i;
        logic signed [31:0] base, m;
        style = $urandom_range(0, 9);
        base  = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        for (i = 0; i < len; i++)
        begin
            case (style)
                0:       m = $urandom;
                1:       m = base;                                    // constant: zero variance
                2:       m = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: m = base + $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
            endcase
            push(m, rand_unc(), $urandom_range(0, 99) < 92, $urandom_range(0, 99) < 92,
                 $urandom_range(0, 99) < 80, i == len - 1);
        end
    endtask

    task automatic random_phase(input int unsigned items);
        int unsigned done_n, len;
        done_n = 0;
        while (done_n < items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: random flags, sometimes a stray series end
                push($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
                done_n++;
            end
            else
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
                random_series(len);
                done_n += len;
            end
        end
        push($urandom, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b1);  // close any open series
    endtask

    initial
    begin
        clear_series();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // unweighted, unmasked: registers at reset values
        reg_write(vnr_pkg::REG_WEIGHTED, 32'd0);
        reg_write(vnr_pkg::REG_MASK, 32'd0);
        push(32'h0001_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b1);  // lone sample: fewer than two
        push(32'h0002_0000, 32'h1_0000, 1'b0, 1'b1, 1'b1, 1'b1);  // last dropped, empty series
        push(32'h0003_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b0);  // constant: zero variance
        push(32'h0003_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b0);
        push(32'h0003_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b1);
        push(32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, 1'b0, 1'b0);       // extremes: largest magnitudes of both signs
        push(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
        push(32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, 1'b0, 1'b0);
        push(32'h8000_0000, 32'h0, 1'b1, 1'b0, 1'b0, 1'b1);
        push(32'h0001_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b0);  // ordinary ratio
        push(32'h0002_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b0);
        push(32'hFFFC_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b1);
        drain();

        // weighted
        reg_write(vnr_pkg::REG_WEIGHTED, 32'd1);
        push(32'h0001_0000, 32'h0, 1'b1, 1'b1, 1'b1, 1'b0);       // zero error: dropped
        push(32'h0002_0000, 32'h1_0000, 1'b1, 1'b0, 1'b1, 1'b0);  // error invalid: dropped
        push(32'h0001_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b0);
        push(32'h0003_0000, 32'h2_0000, 1'b1, 1'b1, 1'b1, 1'b0);
        push(32'h0002_0000, 32'h0_8000, 1'b1, 1'b1, 1'b1, 1'b1);
        push(32'h0001_0000, 32'h1, 1'b1, 1'b1, 1'b1, 1'b0);       // tiny error: large weight
        push(32'h0005_0000, 32'h1, 1'b1, 1'b1, 1'b1, 1'b1);
        push(32'h0001_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);  // huge error: tiny weight
        push(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        drain();

        // masked, unweighted
        reg_write(vnr_pkg::REG_WEIGHTED, 32'd0);
        reg_write(vnr_pkg::REG_MASK, 32'd1);
        push(32'h0001_0000, 32'h1_0000, 1'b1, 1'b1, 1'b0, 1'b0);  // masked out
        push(32'h0002_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b0);
        push(32'h0004_0000, 32'h1_0000, 1'b1, 1'b1, 1'b1, 1'b1);
        random_phase(280);
        drain();

        reg_write(vnr_pkg::REG_WEIGHTED, 32'd1);
        random_phase(220);
        drain();

        reg_write(vnr_pkg::REG_MASK, 32'd0);
        quiet = 1'b1;
        random_phase(200);
        drain();
        quiet = 1'b0;

        reg_write(vnr_pkg::REG_WEIGHTED, 32'd0);
        random_phase(480);
        drain();

        if (mismatches == 0)
            $display("von_neumann_ratio_top_tb: clean");
        else
            $display("von_neumann_ratio_top_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/vnr_pkg.sv
rtl/vnr_front.sv
rtl/vnr_mul.sv
rtl/vnr_div.sv
rtl/vnr_back.sv
rtl/von_neumann_ratio_top.sv
tb/von_neumann_ratio_top_tb.sv
